// File: sv/tctr_pkg.sv
// Package for the connection table receiver: sizes, codes and the
// entry and table-write structs shared by the sequencer and the table.
package tctr_pkg;
    localparam int MaxConn      = 8;
    localparam int IdxW         = 3;
    localparam int RecvBufBytes = 4096;
    localparam int CwTicks      = 1000;

    localparam logic [2:0] OP_SEG     = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_OPEN    = 3'd2;
    localparam logic [2:0] OP_LISTEN  = 3'd3;
    localparam logic [2:0] OP_CLOSE   = 3'd4;
    localparam logic [2:0] OP_CONSUME = 3'd5;

    localparam logic [1:0] SEG_SYN  = 2'd0;
    localparam logic [1:0] SEG_FIN  = 2'd1;
    localparam logic [1:0] SEG_DATA = 2'd2;
    localparam logic [1:0] SEG_OTHER = 2'd3;

    localparam logic [1:0] ST_CLOSED    = 2'd0;
    localparam logic [1:0] ST_LISTENING = 2'd1;
    localparam logic [1:0] ST_CONNECTED = 2'd2;
    localparam logic [1:0] ST_CLOSEWAIT = 2'd3;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NO_ENTRY = 3'd1;
    localparam logic [2:0] STS_WRONG    = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_NO_DATA  = 3'd4;
    localparam logic [2:0] STS_NO_MATCH = 3'd5;
    localparam logic [2:0] STS_BUF_FULL = 3'd6;

    localparam logic [1:0] RPL_SYNACK  = 2'd0;
    localparam logic [1:0] RPL_FINACK  = 2'd1;
    localparam logic [1:0] RPL_DATAACK = 2'd2;

    // one table entry as seen on the read port
    typedef struct packed {
        logic        used;
        logic [15:0] sport;
        logic [15:0] cport;
        logic [1:0]  state;
        logic [31:0] seq;
        logic [12:0] bytes;
        logic [15:0] timer;
    } entry_t;

    // one write into the table
    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] idx;
        entry_t          data;
    } entry_wr_t;
endpackage

// File: sv/tctr_table.sv
// Connection table: eight entries in flip-flops, one read and one write port.
// Depends on tctr_pkg.
module tctr_table (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [tctr_pkg::IdxW-1:0] rd_idx,
    output tctr_pkg::entry_t       rd_data,
    input  tctr_pkg::entry_wr_t    wr
);
    import tctr_pkg::*;

    entry_t ent_reg [MaxConn];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MaxConn; i++) begin
                ent_reg[i].used  <= 1'b0;
                ent_reg[i].state <= ST_CLOSED;
                ent_reg[i].seq   <= '0;
                ent_reg[i].bytes <= '0;
                ent_reg[i].timer <= '0;
            end
        end else if (wr.we) begin
            ent_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = ent_reg[rd_idx];
endmodule

// File: sv/transport_conn_table_receiver_top.sv
// Connection table receiver, top level: input register, scan sequencer,
// result register. Depends on tctr_pkg and tctr_table.
//
// One item is taken at a time; s_axis_tready is low while it is worked on.
// Segments, ticks and opens scan the eight-entry table one entry per cycle
// through a single read/compare/update path: accept, up to eight scan
// steps, then an update step for a matched segment, then the result.
// Listen, close and consume read the selected entry directly.
// The result waits in m_axis until taken, then the next item is accepted.
module transport_conn_table_receiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0] seg_type[4:3] remote_port[20:5] local_port[36:21]
    // seq_value[68:37] byte_count[81:69] socket_sel[84:82], zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0] socket_out[5:3] reply_valid[6] reply_type[8:7]
    // reply_src_port[24:9] reply_dest_port[40:25] reply_ack_value[72:41]
    // connected_event[73], zero fill
    output logic [79:0] m_axis_tdata
);
    import tctr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [87:0]     in_reg;
    logic [IdxW:0]   cnt_reg, cnt_next;
    logic [79:0]     out_reg, out_next;
    logic [IdxW-1:0] rd_idx;
    entry_t          ent;
    entry_wr_t       wr;

    logic [2:0]  op;
    logic [1:0]  stype;
    logic [15:0] rport, lport;
    logic [31:0] seqv;
    logic [12:0] len;
    logic [2:0]  sel;

    assign op    = in_reg[2:0];
    assign stype = in_reg[4:3];
    assign rport = in_reg[20:5];
    assign lport = in_reg[36:21];
    assign seqv  = in_reg[68:37];
    assign len   = in_reg[81:69];
    assign sel   = in_reg[84:82];

    tctr_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .rd_data (ent),
        .wr      (wr)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = out_reg;

    logic        is_scan;
    logic        hit;
    logic [13:0] sum;
    logic [2:0]  sts;
    logic        rv, cev;
    logic [1:0]  rt;
    entry_t      nd;

    assign is_scan = (op == OP_SEG) || (op == OP_TICK) || (op == OP_OPEN);
    assign rd_idx  = is_scan ? cnt_reg[IdxW-1:0] : sel;
    assign sum     = {1'b0, ent.bytes} + {1'b0, len};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        wr         = '0;
        wr.idx     = rd_idx;
        nd         = ent;
        sts        = STS_OK;
        rv         = 1'b0;
        cev        = 1'b0;
        rt         = RPL_SYNACK;
        hit        = ent.used && (ent.sport == lport)
                     && ((stype == SEG_SYN) || (ent.cport == rport));
        case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                if (s_axis_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // one entry per cycle; ends on hit, free slot or table end
                case (op)
                    OP_SEG: begin
                        if (stype == SEG_OTHER) begin
                            out_next   = '0;
                            state_next = S_OUT;
                        end else if (hit) begin
                            state_next = S_DONE;
                        end else if (cnt_reg == (IdxW+1)'(MaxConn - 1)) begin
                            out_next      = '0;
                            out_next[2:0] = STS_NO_MATCH;
                            state_next    = S_OUT;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (ent.state == ST_CLOSEWAIT) begin
                            wr.we = 1'b1;
                            if (ent.timer != 16'd0) nd.timer = ent.timer - 16'd1;
                            if (nd.timer == 16'd0) nd.state = ST_CLOSED;
                        end
                        if (cnt_reg == (IdxW+1)'(MaxConn - 1)) begin
                            out_next   = '0;
                            state_next = S_OUT;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    OP_OPEN: begin
                        out_next = '0;
                        if (!ent.used) begin
                            wr.we    = 1'b1;
                            nd.used  = 1'b1;
                            nd.sport = lport;
                            nd.state = ST_CLOSED;
                            nd.seq   = '0;
                            nd.bytes = '0;
                            nd.timer = '0;
                            out_next[5:3] = cnt_reg[IdxW-1:0];
                            state_next    = S_OUT;
                        end else if (cnt_reg == (IdxW+1)'(MaxConn - 1)) begin
                            out_next[2:0] = STS_FULL;
                            state_next    = S_OUT;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    default: begin
                        out_next   = '0;
                        state_next = S_OUT;
                        if (op == OP_LISTEN || op == OP_CLOSE || op == OP_CONSUME) begin
                            if (!ent.used) begin
                                out_next[2:0] = STS_NO_ENTRY;
                            end else if (op == OP_LISTEN) begin
                                if (ent.state == ST_CLOSED) begin
                                    wr.we    = 1'b1;
                                    nd.state = ST_LISTENING;
                                end else if (ent.state != ST_LISTENING) begin
                                    out_next[2:0] = STS_WRONG;
                                end
                            end else if (op == OP_CLOSE) begin
                                if (ent.state == ST_CLOSED) begin
                                    wr.we    = 1'b1;
                                    nd.used  = 1'b0;
                                    nd.bytes = '0;
                                    nd.timer = '0;
                                end else begin
                                    out_next[2:0] = STS_WRONG;
                                end
                            end else begin
                                if (ent.state != ST_CONNECTED) begin
                                    out_next[2:0] = STS_WRONG;
                                end else if (ent.bytes < len) begin
                                    out_next[2:0] = STS_NO_DATA;
                                end else begin
                                    wr.we    = 1'b1;
                                    nd.bytes = ent.bytes - len;
                                end
                            end
                        end
                    end
                endcase
            end
            S_DONE: begin
                // matched segment: update the entry if allowed and build the result
                state_next = S_OUT;
                case (stype)
                    SEG_SYN: begin
                        if (ent.state == ST_LISTENING) begin
                            nd.state = ST_CONNECTED;
                            cev      = 1'b1;
                        end
                        if (nd.state == ST_CONNECTED) begin
                            wr.we    = 1'b1;
                            nd.cport = rport;
                            nd.seq   = seqv + 32'd1;
                            rv       = 1'b1;
                            rt       = RPL_SYNACK;
                        end else begin
                            sts = STS_WRONG;
                        end
                    end
                    SEG_FIN: begin
                        if (ent.state == ST_CONNECTED) begin
                            wr.we    = 1'b1;
                            nd.state = ST_CLOSEWAIT;
                            nd.timer = 16'(CwTicks);
                        end
                        if (nd.state == ST_CLOSEWAIT) begin
                            rv = 1'b1;
                            rt = RPL_FINACK;
                        end else begin
                            sts = STS_WRONG;
                        end
                    end
                    default: begin
                        if (ent.state != ST_CONNECTED) begin
                            sts = STS_WRONG;
                        end else begin
                            rv = 1'b1;
                            rt = RPL_DATAACK;
                            if (ent.seq == seqv) begin
                                if (sum > 14'(RecvBufBytes)) begin
                                    sts = STS_BUF_FULL;
                                end else begin
                                    wr.we    = 1'b1;
                                    nd.seq   = ent.seq + {19'd0, len};
                                    nd.bytes = sum[12:0];
                                end
                            end
                        end
                    end
                endcase
                out_next       = '0;
                out_next[2:0]  = sts;
                out_next[5:3]  = cnt_reg[IdxW-1:0];
                out_next[6]    = rv;
                out_next[73]   = cev;
                if (rv) begin
                    out_next[8:7]   = rt;
                    out_next[24:9]  = ent.sport;
                    out_next[40:25] = (stype == SEG_SYN) ? rport : ent.cport;
                    out_next[72:41] = (stype == SEG_DATA) ? ent.seq : nd.seq;
                end
            end
            default: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
        endcase
        wr.data = nd;
    end

    // DATA ack carries the updated number when accepted
    logic [31:0] data_ack;
    assign data_ack = wr.we ? wr.data.seq : ent.seq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_axis_tvalid) in_reg <= s_axis_tdata;
        if (state_reg == S_DONE && stype == SEG_DATA && out_next[6]) begin
            out_reg <= {out_next[79:73], data_ack, out_next[40:0]};
        end else begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_write_when_work: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> (state_reg == S_SCAN || state_reg == S_DONE))
        else $error("table write outside work");
    a_event_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[73] |-> m_axis_tdata[6])
        else $error("connect event without reply");
`endif
endmodule
